[src/sorted_array_table_core_assert.svh]
// Assertion macros for the sorted array table RTL.
`ifndef SORTED_ARRAY_TABLE_CORE_ASSERT_SVH
`define SORTED_ARRAY_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAT_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sat_pkg.sv]
// Types and constants of the sorted array table.
package sat_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int CNT_W = 7;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2
    } req_code_t;

    // Status codes carried in the result item.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_INDEX = 2'd2,
        STAT_NO_MATCH  = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_DEL,
        ST_SRCH,
        ST_RESP
    } sat_state_t;

endpackage

[src/sat_if.sv]
// Request and response channel interfaces of the sorted array table.
interface sat_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       req_type;
    logic signed [sat_pkg::VAL_W-1:0] item_value;
    logic [sat_pkg::POS_W-1:0]        position;

    modport source (output valid, output req_type, output item_value, output position,
                    input ready);
    modport sink (input valid, input req_type, input item_value, input position,
                  output ready);
endinterface

interface sat_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [sat_pkg::POS_W-1:0]        found_index;
    logic signed [sat_pkg::VAL_W-1:0] removed_value;
    logic [sat_pkg::CNT_W-1:0]        entry_count;
    logic                             last;

    modport source (output valid, output status, output found_index, output removed_value,
                    output entry_count, output last, input ready);
    modport sink (input valid, input status, input found_index, input removed_value,
                  input entry_count, input last, output ready);
endinterface

[src/sorted_array_table_core.sv]
// Sorted array table: insert, delete at index and search over one entry RAM.
// One request is worked at a time. An insert scans from the top of the table down to its
// place, a delete from its position up to the top, and a search the whole table; the scan
// moves one entry per cycle, though a search scan waits while the result output stalls.
// A full-table insert or a bad-index delete skips the scan and goes straight to the result,
// and the next request is taken once the final result appears. Reset clears the count, not the RAM.
`include "sorted_array_table_core_assert.svh"

module sorted_array_table_core #(
    parameter int DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    sat_req_if.sink    request,
    sat_rsp_if.source  response
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [sat_pkg::CNT_W-1:0] DEPTH_CNT = sat_pkg::CNT_W'(DEPTH);

    sat_pkg::sat_state_t state_reg, state_next;

    logic [sat_pkg::CNT_W-1:0]        count_reg, count_next;
    logic signed [sat_pkg::VAL_W-1:0] val_reg, val_next;
    logic [sat_pkg::CNT_W-1:0]        pos_reg, pos_next;
    logic [sat_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic                             rd_vld_reg, rd_vld_next;
    logic [sat_pkg::CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic signed [sat_pkg::VAL_W-1:0] removed_reg, removed_next;
    sat_pkg::status_t                 st_reg, st_next;
    logic                             pend_vld_reg, pend_vld_next;
    logic [sat_pkg::POS_W-1:0]        pend_idx_reg, pend_idx_next;

    logic                             out_vld_reg, out_vld_next;
    sat_pkg::status_t                 out_status_reg, out_status_next;
    logic [sat_pkg::POS_W-1:0]        out_found_reg, out_found_next;
    logic signed [sat_pkg::VAL_W-1:0] out_removed_reg, out_removed_next;
    logic [sat_pkg::CNT_W-1:0]        out_count_reg, out_count_next;
    logic                             out_last_reg, out_last_next;

    logic                             ram_we;
    logic [sat_pkg::CNT_W-1:0]        ram_waddr;
    logic [sat_pkg::VAL_W-1:0]        ram_wdata;
    logic                             ram_re;
    logic [sat_pkg::CNT_W-1:0]        ram_raddr;
    logic [sat_pkg::VAL_W-1:0]        ram_q;

    logic accept;
    logic can_go;
    logic ins_hit;
    logic ins_end;
    logic ins_done;
    logic del_end;
    logic srch_end;
    logic [sat_pkg::CNT_W-1:0] req_pos;

    // Entry storage.
    sat_ram #(
        .WIDTH (sat_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr[AW-1:0]),
        .rdata (ram_q)
    );

    // Handshake and scan termination conditions.
    assign request.ready = (state_reg == sat_pkg::ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign can_go        = !out_vld_reg || response.ready;
    assign req_pos       = {1'b0, request.position};
    assign ins_hit       = rd_vld_reg && !($signed(ram_q) > val_reg);
    assign ins_end       = ins_hit || (!rd_vld_reg && (idx_reg == '0));
    assign ins_done      = (state_reg == sat_pkg::ST_INS) && ins_end;
    assign del_end       = !rd_vld_reg && (idx_reg == count_reg);
    assign srch_end      = can_go && !rd_vld_reg && (idx_reg == count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sat_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.req_type)
                        sat_pkg::REQ_INSERT:
                            state_next = (count_reg >= DEPTH_CNT) ? sat_pkg::ST_RESP
                                                                  : sat_pkg::ST_INS;
                        sat_pkg::REQ_DELETE:
                            state_next = (req_pos >= count_reg) ? sat_pkg::ST_RESP
                                                                : sat_pkg::ST_DEL;
                        sat_pkg::REQ_SEARCH:
                            state_next = sat_pkg::ST_SRCH;
                        default:
                            state_next = sat_pkg::ST_IDLE;
                    endcase
                end
            end
            sat_pkg::ST_INS:
            begin
                if (ins_end)
                begin
                    state_next = sat_pkg::ST_RESP;
                end
            end
            sat_pkg::ST_DEL:
            begin
                if (del_end)
                begin
                    state_next = sat_pkg::ST_RESP;
                end
            end
            sat_pkg::ST_SRCH:
            begin
                if (srch_end)
                begin
                    state_next = sat_pkg::ST_RESP;
                end
            end
            sat_pkg::ST_RESP:
            begin
                if (can_go)
                begin
                    state_next = sat_pkg::ST_IDLE;
                end
            end
            default:
                state_next = sat_pkg::ST_IDLE;
        endcase
    end

    // Datapath: RAM accesses, scan counters and result loading.
    always_comb
    begin
        count_next       = count_reg;
        val_next         = val_reg;
        pos_next         = pos_reg;
        idx_next         = idx_reg;
        rd_vld_next      = rd_vld_reg;
        rd_idx_next      = rd_idx_reg;
        removed_next     = removed_reg;
        st_next          = st_reg;
        pend_vld_next    = pend_vld_reg;
        pend_idx_next    = pend_idx_reg;
        out_vld_next     = out_vld_reg && !response.ready;
        out_status_next  = out_status_reg;
        out_found_next   = out_found_reg;
        out_removed_next = out_removed_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = val_reg;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        unique case (state_reg)
            sat_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    val_next      = request.item_value;
                    pos_next      = req_pos;
                    removed_next  = '0;
                    pend_vld_next = 1'b0;
                    pend_idx_next = '0;
                    rd_vld_next   = 1'b0;
                    st_next       = sat_pkg::STAT_OK;
                    case (request.req_type)
                        sat_pkg::REQ_INSERT:
                        begin
                            idx_next = count_reg;
                            if (count_reg >= DEPTH_CNT)
                            begin
                                st_next = sat_pkg::STAT_FULL;
                            end
                        end
                        sat_pkg::REQ_DELETE:
                        begin
                            idx_next = req_pos;
                            if (req_pos >= count_reg)
                            begin
                                st_next = sat_pkg::STAT_BAD_INDEX;
                            end
                        end
                        default:
                            idx_next = '0;
                    endcase
                end
            end

            // Walk down from the top, moving greater entries up by one.
            sat_pkg::ST_INS:
            begin
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg + 7'd1;
                    ram_wdata = ins_hit ? val_reg : ram_q;
                end
                else if (idx_reg == '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = val_reg;
                end
                if (ins_end)
                begin
                    count_next  = count_reg + 7'd1;
                    rd_vld_next = 1'b0;
                end
                else if (idx_reg != '0)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = idx_reg - 7'd1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg - 7'd1;
                    idx_next    = idx_reg - 7'd1;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
            end

            // Read the removed entry, then move each later entry down by one.
            sat_pkg::ST_DEL:
            begin
                if (rd_vld_reg)
                begin
                    if (rd_idx_reg == pos_reg)
                    begin
                        removed_next = ram_q;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = rd_idx_reg - 7'd1;
                        ram_wdata = ram_q;
                    end
                end
                if (idx_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = idx_reg;
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg;
                    idx_next    = idx_reg + 7'd1;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
                if (del_end)
                begin
                    count_next = count_reg - 7'd1;
                end
            end

            // Scan upward; a hit is held back until the next one shows it is not last.
            sat_pkg::ST_SRCH:
            begin
                if (can_go)
                begin
                    if (rd_vld_reg && (ram_q == val_reg))
                    begin
                        if (pend_vld_reg)
                        begin
                            out_vld_next     = 1'b1;
                            out_status_next  = sat_pkg::STAT_OK;
                            out_found_next   = pend_idx_reg;
                            out_removed_next = '0;
                            out_count_next   = count_reg;
                            out_last_next    = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_idx_next = rd_idx_reg[sat_pkg::POS_W-1:0];
                    end
                    if (idx_reg < count_reg)
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = idx_reg;
                        rd_vld_next = 1'b1;
                        rd_idx_next = idx_reg;
                        idx_next    = idx_reg + 7'd1;
                    end
                    else
                    begin
                        rd_vld_next = 1'b0;
                    end
                    if (srch_end)
                    begin
                        st_next = pend_vld_reg ? sat_pkg::STAT_OK : sat_pkg::STAT_NO_MATCH;
                    end
                end
            end

            // Final item of the request.
            sat_pkg::ST_RESP:
            begin
                if (can_go)
                begin
                    out_vld_next     = 1'b1;
                    out_status_next  = st_reg;
                    out_found_next   = pend_idx_reg;
                    out_removed_next = removed_reg;
                    out_count_next   = count_reg;
                    out_last_next    = 1'b1;
                end
            end

            default:
            begin
                rd_vld_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sat_pkg::ST_IDLE;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        val_reg         <= val_next;
        pos_reg         <= pos_next;
        idx_reg         <= idx_next;
        rd_idx_reg      <= rd_idx_next;
        removed_reg     <= removed_next;
        st_reg          <= st_next;
        pend_idx_reg    <= pend_idx_next;
        out_status_reg  <= out_status_next;
        out_found_reg   <= out_found_next;
        out_removed_reg <= out_removed_next;
        out_count_reg   <= out_count_next;
        out_last_reg    <= out_last_next;
    end

    // Result channel.
    assign response.valid         = out_vld_reg;
    assign response.status        = out_status_reg;
    assign response.found_index   = out_found_reg;
    assign response.removed_value = out_removed_reg;
    assign response.entry_count   = out_count_reg;
    assign response.last          = out_last_reg;

    // Checks on the table bookkeeping.
    `SAT_ASSERT_HOLDS(a_count_bound, 1'b1, count_reg <= DEPTH_CNT, "entry count above depth")
    `SAT_ASSERT_HOLDS(a_write_in_table, ram_we, ram_waddr <= count_reg, "write beyond table end")
    `SAT_ASSERT_NEXT(a_ins_grows, ins_done, count_reg == $past(count_reg) + 7'd1, "count stuck")

endmodule

[src/sat_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[bench/tb.sv]
// Self-checking testbench for the sorted array table core: directed and random requests.
module tb;

    localparam int DEPTH = 64;
    // The package has no name for the spare request code, which is ignored.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // A full search scan plus margin.
    localparam int TAIL_CYCLES = 3 * DEPTH;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;

    // One response item as the block should produce it.
    typedef struct {
        sat_pkg::status_t                 status;
        logic [sat_pkg::POS_W-1:0]        found_index;
        logic signed [sat_pkg::VAL_W-1:0] removed_value;
        logic [sat_pkg::CNT_W-1:0]        entry_count;
        logic                             last;
    } table_rsp_t;

    // Mirror of the table contents and the queue of responses still owed.
    class table_scoreboard;
        logic signed [sat_pkg::VAL_W-1:0] tbl [DEPTH];
        int                               cnt;
        table_rsp_t                       owed_q[$];
        int                               mismatches;

        function new();
            cnt = 0;
            mismatches = 0;
        endfunction

        function void owe(sat_pkg::status_t st, int idx,
                          logic signed [sat_pkg::VAL_W-1:0] removed, logic last);
            table_rsp_t r;
            r.status        = st;
            r.found_index   = idx[sat_pkg::POS_W-1:0];
            r.removed_value = removed;
            r.entry_count   = cnt[sat_pkg::CNT_W-1:0];
            r.last          = last;
            owed_q.push_back(r);
        endfunction

        // Update the mirror for an accepted request and queue what it owes.
        function void note_request(logic [1:0] kind, logic signed [sat_pkg::VAL_W-1:0] value,
                                   logic [sat_pkg::POS_W-1:0] pos);
            int at;
            int hits;
            logic signed [sat_pkg::VAL_W-1:0] removed;
            if (kind == sat_pkg::REQ_INSERT)
            begin
                if (cnt >= DEPTH)
                begin
                    owe(sat_pkg::STAT_FULL, 0, '0, 1'b1);
                end
                else
                begin
                    // The new value lands in front of the first strictly greater entry.
                    at = cnt;
                    for (int i = 0; i < cnt; i++)
                    begin
                        if (tbl[i] > value)
                        begin
                            at = i;
                            break;
                        end
                    end
                    for (int i = cnt; i > at; i--)
                        tbl[i] = tbl[i-1];
                    tbl[at] = value;
                    cnt++;
                    owe(sat_pkg::STAT_OK, 0, '0, 1'b1);
                end
            end
            else if (kind == sat_pkg::REQ_DELETE)
            begin
                if (pos >= cnt)
                begin
                    owe(sat_pkg::STAT_BAD_INDEX, 0, '0, 1'b1);
                end
                else
                begin
                    removed = tbl[pos];
                    for (int i = pos; i + 1 < cnt; i++)
                        tbl[i] = tbl[i+1];
                    cnt--;
                    owe(sat_pkg::STAT_OK, 0, removed, 1'b1);
                end
            end
            else if (kind == sat_pkg::REQ_SEARCH)
            begin
                // Every matching index in ascending order; the final one is marked.
                hits = 0;
                for (int i = 0; i < cnt; i++)
                begin
                    if (tbl[i] == value)
                    begin
                        owe(sat_pkg::STAT_OK, i, '0, 1'b0);
                        hits++;
                    end
                end
                if (hits == 0)
                    owe(sat_pkg::STAT_NO_MATCH, 0, '0, 1'b1);
                else
                    owed_q[$].last = 1'b1;
            end
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: %s", what);
        endfunction

        // Compare one accepted response against the oldest one owed.
        function void check_result(table_rsp_t got);
            table_rsp_t want;
            if (owed_q.size() == 0)
            begin
                report($sformatf("unexpected response status=%0d index=%0d count=%0d",
                                 got.status, got.found_index, got.entry_count));
                return;
            end
            want = owed_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status expected %0d actual %0d", want.status, got.status));
            if (got.found_index !== want.found_index)
                report($sformatf("found_index expected %0d actual %0d",
                                 want.found_index, got.found_index));
            if (got.removed_value !== want.removed_value)
                report($sformatf("removed_value expected %0d actual %0d",
                                 want.removed_value, got.removed_value));
            if (got.entry_count !== want.entry_count)
                report($sformatf("entry_count expected %0d actual %0d",
                                 want.entry_count, got.entry_count));
            if (got.last !== want.last)
                report($sformatf("last expected %0d actual %0d", want.last, got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   cycle_count = 0;
    bit   filling;

    sat_req_if req_ch ();
    sat_rsp_if rsp_ch ();

    table_scoreboard sb = new();

    sorted_array_table_core #(.DEPTH(DEPTH)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Response side: check accepted items, then choose the next ready.
    always @(posedge clk)
    begin : rsp_side
        table_rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status        = sat_pkg::status_t'(rsp_ch.status);
            got.found_index   = rsp_ch.found_index;
            got.removed_value = rsp_ch.removed_value;
            got.entry_count   = rsp_ch.entry_count;
            got.last          = rsp_ch.last;
            sb.check_result(got);
        end
        rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Present one request item, idling first at random, and hold it until accepted.
    task automatic send_item(logic [1:0] kind, logic signed [sat_pkg::VAL_W-1:0] value,
                             logic [sat_pkg::POS_W-1:0] pos);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.item_value <= value;
        req_ch.position   <= pos;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(kind, value, pos);
    endtask

    // Stop sending until every owed response has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.owed_q.size() != 0);
    endtask

    function automatic logic signed [sat_pkg::VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return $signed($urandom_range(6)) - 3;
        if (r == 4)
        begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom());
    endfunction

    // Edges: empty table, extreme values, equal values, bad indexes, spare code.
    task automatic run_directed();
        send_item(sat_pkg::REQ_SEARCH, 32'sd7, '0);
        send_item(sat_pkg::REQ_DELETE, '0, 6'd0);
        send_item(sat_pkg::REQ_DELETE, '0, 6'd63);
        send_item(sat_pkg::REQ_INSERT, 32'sh7fff_ffff, '0);
        send_item(sat_pkg::REQ_INSERT, 32'sh8000_0000, '0);
        send_item(sat_pkg::REQ_INSERT, 32'sd5, '0);
        send_item(sat_pkg::REQ_INSERT, 32'sd5, '0);
        send_item(sat_pkg::REQ_INSERT, -32'sd1, '0);
        send_item(sat_pkg::REQ_INSERT, 32'sd0, 6'd63);
        send_item(sat_pkg::REQ_SEARCH, 32'sd5, '0);
        send_item(sat_pkg::REQ_SEARCH, 32'sh8000_0000, '0);
        send_item(sat_pkg::REQ_SEARCH, 32'sh7fff_ffff, '0);
        send_item(sat_pkg::REQ_SEARCH, 32'sd42, '0);
        send_item(REQ_UNUSED, 32'sh7fff_ffff, 6'd63);
        send_item(sat_pkg::REQ_DELETE, '0, 6'd6);
        send_item(sat_pkg::REQ_DELETE, '0, 6'd0);
        send_item(sat_pkg::REQ_DELETE, '0, 6'd4);
        send_item(sat_pkg::REQ_SEARCH, 32'sd5, '0);
        send_item(sat_pkg::REQ_INSERT, 32'sd5, '0);
        send_item(sat_pkg::REQ_SEARCH, 32'sd5, '0);
    endtask

    // Random requests: fill the table to full, then drain it, with searches mixed in.
    task automatic run_random(int n);
        int done;
        int roll;
        int r;
        logic [1:0]                       kind;
        logic signed [sat_pkg::VAL_W-1:0] value;
        logic [sat_pkg::POS_W-1:0]        pos;
        done = 0;
        while (done < n)
        begin
            if (filling && sb.cnt == DEPTH && $urandom_range(2) == 0)
                filling = 1'b0;
            if (!filling && sb.cnt == 0)
                filling = 1'b1;
            roll  = $urandom_range(99);
            value = pick_value();
            pos   = sat_pkg::POS_W'($urandom_range(DEPTH - 1));
            if (roll < 4)
                kind = REQ_UNUSED;
            else if (filling)
                kind = (roll < 78) ? sat_pkg::REQ_INSERT :
                       (roll < 88) ? sat_pkg::REQ_DELETE : sat_pkg::REQ_SEARCH;
            else
                kind = (roll < 20) ? sat_pkg::REQ_INSERT :
                       (roll < 72) ? sat_pkg::REQ_DELETE : sat_pkg::REQ_SEARCH;
            if (kind == sat_pkg::REQ_SEARCH && sb.cnt > 0 && $urandom_range(9) < 6)
                value = sb.tbl[$urandom_range(sb.cnt - 1)];
            if (kind == sat_pkg::REQ_DELETE)
            begin
                r = $urandom_range(99);
                if (r < 75 && sb.cnt > 0)
                    pos = sat_pkg::POS_W'($urandom_range(sb.cnt - 1));
                else if (r < 85)
                    pos = sat_pkg::POS_W'((sb.cnt < DEPTH) ? sb.cnt : DEPTH - 1);
            end
            send_item(kind, value, pos);
            if (kind != REQ_UNUSED)
                done++;
        end
    endtask

    // Main sequence.
    initial
    begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        filling       = 1'b1;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= sat_pkg::REQ_INSERT;
        req_ch.item_value <= '0;
        req_ch.position   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        wait_drained();

        run_random(35);
        wait_drained();

        src_idle_pct = 53;
        run_random(35);
        wait_drained();

        src_idle_pct  = 0;
        snk_stall_pct = 53;
        run_random(35);
        wait_drained();

        src_idle_pct  = 36;
        snk_stall_pct = 36;
        run_random(35);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
